/* sv/rgbhsv_pkg.sv */
// Shared beat types and fixed-point constants of the RGB/HSV colour converter.
package rgbhsv_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_hue;
    logic [7:0] in_saturation;
    logic [7:0] in_value;
  } in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_hue;
    logic [7:0] out_saturation;
    logic [7:0] out_value;
  } out_t;

  // Operation codes
  localparam logic OpFromRgb = 1'b0;
  localparam logic OpFromHsv = 1'b1;

  localparam logic [7:0] Full8 = 8'd255;

  // Reciprocals for division by a constant: floor(x * K >> S), then one correction step
  localparam logic [9:0] RecipHue = 10'((32'd1 << 17) / 32'd255);
  localparam logic [7:0] RecipPct = 8'((32'd1 << 15) / 32'd255);
  localparam logic [8:0] RecipLv  = 9'((32'd1 << 16) / 32'd200);
  localparam logic [8:0] RecipLm  = 9'((32'd1 << 23) / 32'd20000);
  localparam logic [8:0] RecipLn  = 9'((32'd1 << 29) / 32'd1200000);

endpackage

/* sv/rgb_hsv_color_converter_unit.sv */
// Ten-stage RGB/HSV colour converter: one colour in, all six channels out.
//
// The block takes one colour beat per clock while no result is stalled on the
// output, and returns results in order. For an RGB beat the hue is the exact floor of
// 255 * hexcone fraction, formed by a restoring divider that settles one quotient
// bit per pipeline stage; a grey input gives hue 0, and saturation and value always
// read 255. For an HSV beat the input is echoed and the RGB levels come from a chain of
// small multipliers and reciprocal divisions by constants, one step per stage.
// The whole pipeline holds while a finished result waits on the output, so the
// input is ready whenever the output register is empty or is being taken.
module rgb_hsv_color_converter_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rgbhsv_pkg::in_t    in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rgbhsv_pkg::out_t   out_data_o
);
  import rgbhsv_pkg::*;

  localparam logic [2:0] SecRed     = 3'd0;
  localparam logic [2:0] SecYellow  = 3'd1;
  localparam logic [2:0] SecGreen   = 3'd2;
  localparam logic [2:0] SecCyan    = 3'd3;
  localparam logic [2:0] SecBlue    = 3'd4;
  localparam logic [2:0] SecMagenta = 3'd5;
  localparam logic [2:0] SecWrap    = 3'd6;

  typedef struct packed {
    logic [16:0] xh;
    logic [14:0] xs;
    logic [14:0] xv;
    logic [8:0]  hh;
    logic [6:0]  ss;
    logic [6:0]  vv;
    logic [2:0]  sec;
    logic [5:0]  f;
    logic [12:0] sf;
    logic [6:0]  oms;
    logic [13:0] p;
    logic [19:0] q;
    logic [15:0] nv;
    logic [22:0] nm;
    logic [28:0] nn;
    logic [7:0]  lv;
    logic [7:0]  lm;
    logic [7:0]  ln;
  } hsv_t;

  function automatic logic [19:0] div_step(logic [18:0] rem, logic [10:0] den, logic [2:0] k);
    logic [18:0] sub;
    sub = {8'b0, den} << k;
    if (rem >= sub) begin
      return {1'b1, rem - sub};
    end
    return {1'b0, rem};
  endfunction

  logic        en;
  logic [10:1] vld_q;
  in_t         pl_q [1:9];
  hsv_t        hsv_q [1:9];
  hsv_t        hsv1_d;
  hsv_t        hsv_d [2:9];
  logic [10:0] n1_q, n1_d;
  logic [7:0]  d1_q, d1_d;
  logic [18:0] rem_q [2:9];
  logic [18:0] rem2_d;
  logic [18:0] rem_d [3:9];
  logic [10:0] den_q [2:9];
  logic [10:0] den2_d;
  logic [7:0]  quo_q [2:9];
  logic [7:0]  quo_d [3:9];
  out_t        out_q, out_d;

  // Advance everything unless a result is stuck on the output
  assign en          = !vld_q[10] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[10];
  assign out_data_o  = out_q;

  // Stage 1: hexcone numerator and span; HSV scaled products
  always_comb begin
    logic [7:0] r, g, b, p;
    logic       g_ge_b;
    r      = in_data_i.in_red;
    g      = in_data_i.in_green;
    b      = in_data_i.in_blue;
    g_ge_b = (g >= b);
    p      = g_ge_b ? g : b;
    if (r >= p) begin
      if (g_ge_b) begin
        d1_d = r - b;
        n1_d = {3'b000, g} - {3'b000, b};
      end else begin
        d1_d = r - g;
        n1_d = 11'd6 * {3'b000, d1_d} + {3'b000, g} - {3'b000, b};
      end
    end else begin
      if (g_ge_b) begin
        d1_d = g - ((r < b) ? r : b);
        n1_d = 11'd2 * {3'b000, d1_d} + {3'b000, b} - {3'b000, r};
      end else begin
        d1_d = b - ((r < g) ? r : g);
        n1_d = 11'd4 * {3'b000, d1_d} + {3'b000, r} - {3'b000, g};
      end
    end

    hsv1_d    = '0;
    hsv1_d.xh = {9'b0, in_data_i.in_hue} * 17'd360;
    hsv1_d.xs = {7'b0, in_data_i.in_saturation} * 15'd100;
    hsv1_d.xv = {7'b0, in_data_i.in_value} * 15'd100;
  end

  // Stage 2 of the RGB path: numerator times 255, divisor six spans
  assign rem2_d = {n1_q, 8'b0} - {8'b0, n1_q};
  assign den2_d = {3'b000, d1_q} * 11'd6;

  // One restoring step per stage; quotient shifts in from the bottom
  always_comb begin
    logic [19:0] step;
    for (int j = 3; j <= 9; j++) begin
      step     = div_step(rem_q[j-1], den_q[j-1], 3'(10 - j));
      rem_d[j] = step[18:0];
      quo_d[j] = {quo_q[j-1][6:0], step[19]};
    end
  end

  // HSV path, stages 2 to 9
  always_comb begin
    logic [26:0] ph;
    logic [22:0] ps, pv;
    logic [24:0] plv;
    logic [31:0] plm;
    logic [37:0] pln;
    logic [8:0]  hh;

    hsv_d[2]    = hsv_q[1];
    ph          = {10'b0, hsv_q[1].xh} * {17'b0, RecipHue};
    ps          = {8'b0, hsv_q[1].xs} * {15'b0, RecipPct};
    pv          = {8'b0, hsv_q[1].xv} * {15'b0, RecipPct};
    hsv_d[2].hh = ph[25:17];
    hsv_d[2].ss = ps[21:15];
    hsv_d[2].vv = pv[21:15];

    // Correct the reciprocal estimates, which may fall one short
    hsv_d[3] = hsv_q[2];
    if (hsv_q[2].xh >= ({8'b0, hsv_q[2].hh} + 17'd1) * 17'd255) begin
      hsv_d[3].hh = hsv_q[2].hh + 9'd1;
    end
    if (hsv_q[2].xs >= ({8'b0, hsv_q[2].ss} + 15'd1) * 15'd255) begin
      hsv_d[3].ss = hsv_q[2].ss + 7'd1;
    end
    if (hsv_q[2].xv >= ({8'b0, hsv_q[2].vv} + 15'd1) * 15'd255) begin
      hsv_d[3].vv = hsv_q[2].vv + 7'd1;
    end

    hsv_d[4] = hsv_q[3];
    hh       = hsv_q[3].hh;
    priority if (hh >= 9'd360) begin
      hsv_d[4].sec = SecWrap;
      hsv_d[4].f   = 6'(hh - 9'd360);
    end else if (hh >= 9'd300) begin
      hsv_d[4].sec = SecMagenta;
      hsv_d[4].f   = 6'(hh - 9'd300);
    end else if (hh >= 9'd240) begin
      hsv_d[4].sec = SecBlue;
      hsv_d[4].f   = 6'(hh - 9'd240);
    end else if (hh >= 9'd180) begin
      hsv_d[4].sec = SecCyan;
      hsv_d[4].f   = 6'(hh - 9'd180);
    end else if (hh >= 9'd120) begin
      hsv_d[4].sec = SecGreen;
      hsv_d[4].f   = 6'(hh - 9'd120);
    end else if (hh >= 9'd60) begin
      hsv_d[4].sec = SecYellow;
      hsv_d[4].f   = 6'(hh - 9'd60);
    end else begin
      hsv_d[4].sec = SecRed;
      hsv_d[4].f   = hh[5:0];
    end
    // Rising sectors use the complement of the fraction
    if (!hsv_d[4].sec[0]) begin
      hsv_d[4].f = 6'd60 - hsv_d[4].f;
    end

    hsv_d[5]     = hsv_q[4];
    hsv_d[5].sf  = {6'b0, hsv_q[4].ss} * {7'b0, hsv_q[4].f};
    hsv_d[5].oms = 7'd100 - hsv_q[4].ss;

    hsv_d[6]    = hsv_q[5];
    hsv_d[6].p  = {7'b0, hsv_q[5].vv} * {7'b0, hsv_q[5].oms};
    hsv_d[6].q  = {13'b0, hsv_q[5].vv} * (20'd6000 - {7'b0, hsv_q[5].sf});
    hsv_d[6].nv = {9'b0, hsv_q[5].vv} * 16'd510 + 16'd100;

    hsv_d[7]    = hsv_q[6];
    hsv_d[7].nm = {9'b0, hsv_q[6].p} * 23'd510 + 23'd10000;
    hsv_d[7].nn = {9'b0, hsv_q[6].q} * 29'd510 + 29'd600000;

    hsv_d[8]    = hsv_q[7];
    plv         = {9'b0, hsv_q[7].nv} * {16'b0, RecipLv};
    plm         = {9'b0, hsv_q[7].nm} * {23'b0, RecipLm};
    pln         = {9'b0, hsv_q[7].nn} * {29'b0, RecipLn};
    hsv_d[8].lv = plv[23:16];
    hsv_d[8].lm = plm[30:23];
    hsv_d[8].ln = pln[36:29];

    hsv_d[9] = hsv_q[8];
    if (hsv_q[8].nv >= ({8'b0, hsv_q[8].lv} + 16'd1) * 16'd200) begin
      hsv_d[9].lv = hsv_q[8].lv + 8'd1;
    end
    if (hsv_q[8].nm >= ({15'b0, hsv_q[8].lm} + 23'd1) * 23'd20000) begin
      hsv_d[9].lm = hsv_q[8].lm + 8'd1;
    end
    if (hsv_q[8].nn >= ({21'b0, hsv_q[8].ln} + 29'd1) * 29'd1200000) begin
      hsv_d[9].ln = hsv_q[8].ln + 8'd1;
    end
  end

  // Output stage: last quotient bit, sector routing and echo
  always_comb begin
    logic [19:0] step;
    logic [7:0]  lv, lm, ln;
    step = div_step(rem_q[9], den_q[9], 3'd0);
    lv   = hsv_q[9].lv;
    lm   = hsv_q[9].lm;
    ln   = hsv_q[9].ln;
    if (pl_q[9].op == OpFromRgb) begin
      out_d.out_red        = pl_q[9].in_red;
      out_d.out_green      = pl_q[9].in_green;
      out_d.out_blue       = pl_q[9].in_blue;
      out_d.out_hue        = (den_q[9] == 11'd0) ? 8'd0 : {quo_q[9][6:0], step[19]};
      out_d.out_saturation = Full8;
      out_d.out_value      = Full8;
    end else begin
      unique case (hsv_q[9].sec)
        SecYellow:  {out_d.out_red, out_d.out_green, out_d.out_blue} = {ln, lv, lm};
        SecGreen:   {out_d.out_red, out_d.out_green, out_d.out_blue} = {lm, lv, ln};
        SecCyan:    {out_d.out_red, out_d.out_green, out_d.out_blue} = {lm, ln, lv};
        SecBlue:    {out_d.out_red, out_d.out_green, out_d.out_blue} = {ln, lm, lv};
        SecMagenta: {out_d.out_red, out_d.out_green, out_d.out_blue} = {lv, lm, ln};
        default:    {out_d.out_red, out_d.out_green, out_d.out_blue} = {lv, ln, lm};
      endcase
      out_d.out_hue        = pl_q[9].in_hue;
      out_d.out_saturation = pl_q[9].in_saturation;
      out_d.out_value      = pl_q[9].in_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[9:1], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q     <= n1_d;
      d1_q     <= d1_d;
      pl_q[1]  <= in_data_i;
      hsv_q[1] <= hsv1_d;
      rem_q[2] <= rem2_d;
      den_q[2] <= den2_d;
      quo_q[2] <= '0;
      for (int k = 2; k <= 9; k++) begin
        pl_q[k]  <= pl_q[k-1];
        hsv_q[k] <= hsv_d[k];
      end
      for (int k = 3; k <= 9; k++) begin
        rem_q[k] <= rem_d[k];
        den_q[k] <= den_q[k-1];
        quo_q[k] <= quo_d[k];
      end
      out_q <= out_d;
    end
  end

endmodule

/* sv/rgbhsv_checker.sv */
// Port-level checks of the colour converter and their bind to the top level.
module rgbhsv_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input rgbhsv_pkg::in_t  in_data_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input rgbhsv_pkg::out_t out_data_o
);
  import rgbhsv_pkg::*;

  // A waiting result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result beat changed while stalled");

  // The input side stalls only behind a stuck result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow the output register");

  // Zero saturation can only come from an HSV beat, which must come out grey
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_saturation == 8'd0 |->
      out_data_o.out_red == out_data_o.out_green &&
      out_data_o.out_green == out_data_o.out_blue)
    else $error("unsaturated colour is not grey");

endmodule

bind rgb_hsv_color_converter_unit rgbhsv_checker u_rgbhsv_checker (.*);
